FILE: hw/rtl/gtm_pkg.sv
// Shared types, constants and font ROM for the 5x7 glyph matcher.
`default_nettype none
package gtm_pkg;

    localparam int GLYPH_COUNT   = 39;
    localparam int CELL_PIXELS   = 35;
    localparam int GROUP_SIZE    = 8;
    localparam int GROUP_COUNT   = (GLYPH_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int QUEUE_DEPTH   = 4;
    localparam int MAX_CELLS_DEF = 64;

    localparam logic [5:0] MIN_SCORE_RST = 6'd33;
    localparam logic [6:0] UNKNOWN_CODE  = 7'd63;

    typedef logic [5:0] score_t;
    typedef logic [5:0] gidx_t;

    // One classified cell, handed from the front end to the back end.
    typedef struct packed {
        logic [6:0] char_code;
        logic       recognized;
        gidx_t      glyph_index;
        score_t     peak_score;
        logic       line_end;
    } cls_t;

    // Row 0 lands in the lowest five bits.
    function automatic logic [34:0] pack7(
        input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
        input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
        input logic [4:0] r6);
        return {r6, r5, r4, r3, r2, r1, r0};
    endfunction

    function automatic logic [34:0] glyph_bits(input gidx_t idx);
        logic [34:0] v;
        unique case (idx)
            6'd0:  v = pack7(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
            6'd1:  v = pack7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E);
            6'd2:  v = pack7(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E);
            6'd3:  v = pack7(5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E);
            6'd4:  v = pack7(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
            6'd5:  v = pack7(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10);
            6'd6:  v = pack7(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E);
            6'd7:  v = pack7(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
            6'd8:  v = pack7(5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
            6'd9:  v = pack7(5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E);
            6'd10: v = pack7(5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11);
            6'd11: v = pack7(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
            6'd12: v = pack7(5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11);
            6'd13: v = pack7(5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11);
            6'd14: v = pack7(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
            6'd15: v = pack7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
            6'd16: v = pack7(5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D);
            6'd17: v = pack7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
            6'd18: v = pack7(5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E);
            6'd19: v = pack7(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
            6'd20: v = pack7(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
            6'd21: v = pack7(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
            6'd22: v = pack7(5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11);
            6'd23: v = pack7(5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11);
            6'd24: v = pack7(5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04);
            6'd25: v = pack7(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F);
            6'd26: v = pack7(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
            6'd27: v = pack7(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
            6'd28: v = pack7(5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F);
            6'd29: v = pack7(5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E);
            6'd30: v = pack7(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02);
            6'd31: v = pack7(5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E);
            6'd32: v = pack7(5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E);
            6'd33: v = pack7(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08);
            6'd34: v = pack7(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E);
            6'd35: v = pack7(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C);
            6'd36: v = pack7(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00);
            6'd37: v = pack7(5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00);
            6'd38: v = pack7(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Letters, then digits, then space, hyphen, period.
    function automatic logic [6:0] glyph_code(input gidx_t idx);
        logic [6:0] c;
        if (idx < 6'd26)
            c = 7'd65 + {1'b0, idx};
        else if (idx < 6'd36)
            c = 7'd48 + {1'b0, idx - 6'd26};
        else if (idx == 6'd36)
            c = 7'd32;
        else if (idx == 6'd37)
            c = 7'd45;
        else
            c = 7'd46;
        return c;
    endfunction

    function automatic score_t agree_count(input logic [34:0] v);
        score_t n;
        n = '0;
        for (int i = 0; i < CELL_PIXELS; i++)
            n = n + score_t'(v[i]);
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gtm_front.sv
// Front end: scores a cell against every glyph and picks the best in three stages.
`default_nettype none
module gtm_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [34:0]  cell_bits,
    input  wire logic         last_cell,
    input  wire logic [5:0]   min_score,
    input  wire logic         q_full,
    output logic              push,
    output gtm_pkg::cls_t     push_data
);
    import gtm_pkg::*;

    logic   en;
    logic   a_valid_reg, b_valid_reg, c_valid_reg;
    logic   a_last_reg, b_last_reg;
    score_t a_score_reg [GLYPH_COUNT];
    score_t b_score_reg [GROUP_COUNT];
    gidx_t  b_idx_reg   [GROUP_COUNT];
    cls_t   c_cls_reg;

    score_t a_score_next [GLYPH_COUNT];
    score_t b_score_next [GROUP_COUNT];
    gidx_t  b_idx_next   [GROUP_COUNT];
    cls_t   c_cls_next;
    score_t fin_score;
    gidx_t  fin_idx;

    assign en        = !c_valid_reg || !q_full;
    assign in_ready  = en;
    assign push      = c_valid_reg && !q_full;
    assign push_data = c_cls_reg;

    always_comb
    begin
        for (int g = 0; g < GLYPH_COUNT; g++)
            a_score_next[g] = agree_count(~(cell_bits ^ glyph_bits(gidx_t'(g))));
    end

    // Per-group argmax; strict compare keeps the lowest index on a tie.
    always_comb
    begin
        for (int k = 0; k < GROUP_COUNT; k++) begin
            b_score_next[k] = a_score_reg[k * GROUP_SIZE];
            b_idx_next[k]   = gidx_t'(k * GROUP_SIZE);
            for (int j = 1; j < GROUP_SIZE; j++) begin
                if (k * GROUP_SIZE + j < GLYPH_COUNT) begin
                    if (a_score_reg[k * GROUP_SIZE + j] > b_score_next[k]) begin
                        b_score_next[k] = a_score_reg[k * GROUP_SIZE + j];
                        b_idx_next[k]   = gidx_t'(k * GROUP_SIZE + j);
                    end
                end
            end
        end
    end

    always_comb
    begin
        fin_score = b_score_reg[0];
        fin_idx   = b_idx_reg[0];
        for (int k = 1; k < GROUP_COUNT; k++) begin
            if (b_score_reg[k] > fin_score) begin
                fin_score = b_score_reg[k];
                fin_idx   = b_idx_reg[k];
            end
        end
        c_cls_next.recognized  = (fin_score >= min_score);
        c_cls_next.char_code   = c_cls_next.recognized ? glyph_code(fin_idx) : UNKNOWN_CODE;
        c_cls_next.glyph_index = fin_idx;
        c_cls_next.peak_score  = fin_score;
        c_cls_next.line_end    = b_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a_score_reg <= a_score_next;
            a_last_reg  <= last_cell;
            b_score_reg <= b_score_next;
            b_idx_reg   <= b_idx_next;
            b_last_reg  <= a_last_reg;
            c_cls_reg   <= c_cls_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/gtm_queue.sv
// Small FIFO between the front end and the back end.
`default_nettype none
module gtm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire gtm_pkg::cls_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output gtm_pkg::cls_t      q_data
);
    import gtm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cls_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/gtm_back.sv
// Back end: line counters and the output register.
`default_nettype none
module gtm_back #(
    parameter int MAX_CELLS = gtm_pkg::MAX_CELLS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire gtm_pkg::cls_t q_data,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output gtm_pkg::cls_t      out_cls,
    output logic [6:0]         matched_count,
    output logic [6:0]         cell_count
);
    import gtm_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_CELLS);

    logic             out_valid_reg;
    cls_t             out_cls_reg;
    logic [6:0]       matched_out_reg, cells_out_reg;
    logic [CNT_W-1:0] cells_total_reg, matched_total_reg;
    logic [CNT_W-1:0] cells_inc, matched_inc;
    logic [CNT_W+6:0] cells_ext, matched_ext;

    assign pop = q_valid && (!out_valid_reg || out_ready);

    assign cells_inc   = (cells_total_reg < MAX_C) ? cells_total_reg + 1'b1 : MAX_C;
    assign matched_inc = !q_data.recognized ? matched_total_reg
                       : (matched_total_reg < MAX_C) ? matched_total_reg + 1'b1 : MAX_C;
    assign cells_ext   = {7'b0, cells_inc};
    assign matched_ext = {7'b0, matched_inc};

    assign out_valid     = out_valid_reg;
    assign out_cls       = out_cls_reg;
    assign matched_count = matched_out_reg;
    assign cell_count    = cells_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg     <= 1'b0;
            cells_total_reg   <= '0;
            matched_total_reg <= '0;
        end else begin
            if (pop) begin
                out_valid_reg <= 1'b1;
                if (q_data.line_end) begin
                    cells_total_reg   <= '0;
                    matched_total_reg <= '0;
                end else begin
                    cells_total_reg   <= cells_inc;
                    matched_total_reg <= matched_inc;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_cls_reg     <= q_data;
            cells_out_reg   <= cells_ext[6:0];
            matched_out_reg <= matched_ext[6:0];
        end
    end

`ifndef SYNTHESIS
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_data.line_end) |=> (cells_total_reg == '0 && matched_total_reg == '0))
        else $error("line counters not cleared after last cell");
    a_cells_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cells_total_reg <= MAX_C)
        else $error("cell count above saturation limit");
    a_matched_le_cells: assert property (@(posedge clk) disable iff (!rst_n)
        matched_total_reg <= cells_total_reg)
        else $error("matched count exceeds cell count");
    a_rec_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_data.recognized) |=> (matched_out_reg != '0 || CNT_W > 7))
        else $error("recognized cell shows zero matched count");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/glyph_template_matcher_5x7.sv
// Top level of the 5x7 glyph template matcher.
// An accepted cell passes the front-end stages, the queue and the output register before it shows on m_tvalid.
// Throughput: one cell per cycle while the queue has room; the 39 glyph scores are computed in parallel,
// reduced over a registered 3-stage tree, then queued (4 entries) to the counter stage.
// Reset: line counts clear to 0, min_score returns to 33, pipeline and queue empty.
`default_nettype none
module glyph_template_matcher_5x7 #(
    parameter int MAX_CELLS = gtm_pkg::MAX_CELLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [34:0] cell_bits, upper bits zero
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] char_code, [12:7] glyph_index, [18:13] peak_score,
    // [25:19] matched_count, [32:26] cell_count, upper bits zero
    output logic [39:0]      m_tdata,
    output logic             m_tuser,   // [0] recognized
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data
);
    import gtm_pkg::*;

    logic       [5:0] min_score_reg;
    logic             q_full, push, pop, q_valid, out_valid;
    cls_t             push_data, q_data, out_cls;
    logic       [6:0] matched_count, cell_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_score_reg <= MIN_SCORE_RST;
        else if (cfg_valid)
            min_score_reg <= cfg_data;
    end

    gtm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cell_bits (s_tdata[34:0]),
        .last_cell (s_tlast),
        .min_score (min_score_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    gtm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    gtm_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (m_tready),
        .out_cls       (out_cls),
        .matched_count (matched_count),
        .cell_count    (cell_count)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'b0, cell_count, matched_count, out_cls.peak_score,
                       out_cls.glyph_index, out_cls.char_code};
    assign m_tuser  = out_cls.recognized;
    assign m_tlast  = out_cls.line_end;

endmodule
`default_nettype wire
